/* rtl/core/skts_pkg.sv */
// Shared types, constants and codes for the sorted key table search core.
package skts_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 32;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_SEARCH = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]              action;
        logic signed [KEY_W-1:0] key;
    } skts_cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] position;
        logic [7:0] stored_count;
    } skts_rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_SRCH_RD,
        S_SRCH_CMP
    } skts_state_t;

    typedef enum logic [2:0] {
        FIN_NOP,
        FIN_CLEAR,
        FIN_FULL,
        FIN_PLACED,
        FIN_FOUND,
        FIN_MISS
    } skts_fin_t;

    typedef struct packed {
        logic      load;
        logic      ins_read;
        logic      ins_shift;
        logic      ins_place;
        logic      srch_read;
        logic      srch_narrow;
        logic      finish;
        skts_fin_t fin_kind;
    } skts_ctl_t;

    typedef struct packed {
        logic [1:0] action;
        logic       full;
        logic       ins_bottom;
        logic       ins_less;
        logic       srch_empty;
        logic       srch_hit;
    } skts_sts_t;

endpackage

/* rtl/core/sorted_key_table_search_core.sv */
// Top level of the sorted key table search core.
// Clear, unused action codes and an insert into a full table give their
// result in the cycle after the transfer. An insert reads and compares the
// stored keys from the top down, shifts each one greater than the new key
// up one place and then writes the new key; a search ends on a hit or on a
// miss after at most log2(TABLE_DEPTH) + 1 probes. Each shift or probe is
// one read and one compare on the single-port key memory, whose read data
// is registered. The result shows on rsp for one cycle with done high and
// cannot be stalled; busy is low again in that same cycle, so the next item
// may be started with it.
module sorted_key_table_search_core
    import skts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  skts_cmd_t cmd,
    output logic      done,
    output skts_rsp_t rsp
);

    skts_ctl_t ctl;
    skts_sts_t sts;

    skts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    skts_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .ctl   (ctl),
        .sts   (sts),
        .done  (done),
        .rsp   (rsp)
    );

endmodule

/* rtl/core/skts_datapath.sv */
// Datapath: key memory, insert/search index registers, count and result register.
module skts_datapath
    import skts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  skts_cmd_t cmd,
    input  skts_ctl_t ctl,
    output skts_sts_t sts,
    output logic      done,
    output skts_rsp_t rsp
);

    logic signed [KEY_W-1:0] mem [TABLE_DEPTH];
    logic signed [KEY_W-1:0] rd_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [CNT_W-1:0]        j_reg;
    logic [CNT_W-1:0]        lo_reg, hi_reg;
    logic [IDX_W-1:0]        mid_reg;
    logic                    done_reg;
    skts_rsp_t               rsp_reg, rsp_next;

    logic [CNT_W:0]          mid_sum;
    logic [CNT_W-1:0]        mid_full;
    logic [CNT_W-1:0]        j_dec;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic signed [KEY_W-1:0] wr_data;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg} - {{CNT_W{1'b0}}, 1'b1};
    assign mid_full = mid_sum[CNT_W:1];
    assign j_dec    = j_reg - {{(CNT_W-1){1'b0}}, 1'b1};

    assign wr_en   = ctl.ins_shift | ctl.ins_place;
    assign wr_addr = j_reg[IDX_W-1:0];
    assign wr_data = ctl.ins_shift ? rd_reg : key_reg;
    assign rd_en   = ctl.ins_read | ctl.srch_read;
    assign rd_addr = ctl.ins_read ? j_dec[IDX_W-1:0] : mid_full[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    assign sts.action     = cmd.action;
    assign sts.full       = (cnt_reg >= CNT_W'(TABLE_DEPTH));
    assign sts.ins_bottom = (j_reg == '0);
    assign sts.ins_less   = (key_reg < rd_reg);
    assign sts.srch_empty = (lo_reg >= hi_reg);
    assign sts.srch_hit   = (key_reg == rd_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            key_reg <= cmd.key;
            j_reg   <= cnt_reg;
            lo_reg  <= '0;
            hi_reg  <= cnt_reg;
        end
        else
        begin
            if (ctl.ins_shift)
            begin
                j_reg <= j_dec;
            end
            if (ctl.srch_read)
            begin
                mid_reg <= mid_full[IDX_W-1:0];
            end
            if (ctl.srch_narrow)
            begin
                if (sts.ins_less)
                begin
                    hi_reg <= CNT_W'(mid_reg);
                end
                else
                begin
                    lo_reg <= CNT_W'(mid_reg) + {{(CNT_W-1){1'b0}}, 1'b1};
                end
            end
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        rsp_next = rsp_reg;
        if (ctl.finish)
        begin
            rsp_next.status   = ST_OK;
            rsp_next.position = '0;
            case (ctl.fin_kind)
                FIN_CLEAR:  cnt_next = '0;
                FIN_FULL:   rsp_next.status = ST_FULL;
                FIN_PLACED:
                begin
                    cnt_next          = cnt_reg + {{(CNT_W-1){1'b0}}, 1'b1};
                    rsp_next.position = 7'(j_reg);
                end
                FIN_FOUND:  rsp_next.position = 7'(mid_reg);
                FIN_MISS:   rsp_next.status = ST_MISS;
                default:    ;
            endcase
            rsp_next.stored_count = 8'(cnt_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= ctl.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

/* rtl/core/skts_ctrl.sv */
// Controller: sequences clear, insert shifting and binary search steps.
module skts_ctrl
    import skts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  skts_sts_t sts,
    output skts_ctl_t ctl,
    output logic      busy
);

    skts_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (sts.action == ACT_INSERT && !sts.full)
                    begin
                        state_next = S_INS_RD;
                    end
                    else if (sts.action == ACT_SEARCH)
                    begin
                        state_next = S_SRCH_RD;
                    end
                end
            end
            S_INS_RD:
            begin
                state_next = sts.ins_bottom ? S_IDLE : S_INS_CMP;
            end
            S_INS_CMP:
            begin
                state_next = sts.ins_less ? S_INS_RD : S_IDLE;
            end
            S_SRCH_RD:
            begin
                state_next = sts.srch_empty ? S_IDLE : S_SRCH_CMP;
            end
            S_SRCH_CMP:
            begin
                state_next = sts.srch_hit ? S_IDLE : S_SRCH_RD;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl          = '0;
        ctl.fin_kind = FIN_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load = 1'b1;
                    unique case (sts.action)
                        ACT_CLEAR:
                        begin
                            ctl.finish   = 1'b1;
                            ctl.fin_kind = FIN_CLEAR;
                        end
                        ACT_INSERT:
                        begin
                            if (sts.full)
                            begin
                                ctl.finish   = 1'b1;
                                ctl.fin_kind = FIN_FULL;
                            end
                        end
                        ACT_SEARCH: ;
                        default:
                        begin
                            ctl.finish   = 1'b1;
                            ctl.fin_kind = FIN_NOP;
                        end
                    endcase
                end
            end
            S_INS_RD:
            begin
                if (sts.ins_bottom)
                begin
                    ctl.ins_place = 1'b1;
                    ctl.finish    = 1'b1;
                    ctl.fin_kind  = FIN_PLACED;
                end
                else
                begin
                    ctl.ins_read = 1'b1;
                end
            end
            S_INS_CMP:
            begin
                if (sts.ins_less)
                begin
                    ctl.ins_shift = 1'b1;
                end
                else
                begin
                    ctl.ins_place = 1'b1;
                    ctl.finish    = 1'b1;
                    ctl.fin_kind  = FIN_PLACED;
                end
            end
            S_SRCH_RD:
            begin
                if (sts.srch_empty)
                begin
                    ctl.finish   = 1'b1;
                    ctl.fin_kind = FIN_MISS;
                end
                else
                begin
                    ctl.srch_read = 1'b1;
                end
            end
            S_SRCH_CMP:
            begin
                if (sts.srch_hit)
                begin
                    ctl.finish   = 1'b1;
                    ctl.fin_kind = FIN_FOUND;
                end
                else
                begin
                    ctl.srch_narrow = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

/* rtl/core/skts_checker.sv */
// Port-level assertions for the sorted key table search core, with bind.
module skts_checker
    import skts_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input skts_cmd_t cmd,
    input logic      done,
    input skts_rsp_t rsp
);

    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.action == ACT_CLEAR) |=>
            (done && rsp.status == ST_OK && rsp.stored_count == 8'd0))
        else $error("clear did not return an empty table");

    a_search_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.action == ACT_SEARCH) |=> (busy && !done))
        else $error("search finished without probing");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    a_miss_full_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status == ST_MISS || rsp.status == ST_FULL)) |->
            (rsp.position == 7'd0))
        else $error("nonzero position on miss or full");

endmodule

bind sorted_key_table_search_core skts_checker u_skts_checker (.*);

/* dv/skts_tb_pkg.sv */
// Scoreboard for the sorted key table: predicts each result and checks what the core returns.
`timescale 1ns / 1ps
package skts_tb_pkg;
    import skts_pkg::*;

    class key_table_scoreboard;
        logic signed [KEY_W-1:0] keys [TABLE_DEPTH];
        int                      held;
        skts_rsp_t               expected_q [$];
        int                      errors;

        function new();
            held   = 0;
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH %s", $time, msg);
            errors++;
        endtask

        // accepted transfer: update the shadow table and queue its result
        function void note_cmd(skts_cmd_t c);
            skts_rsp_t               r;
            logic signed [KEY_W-1:0] k;
            int                      j;
            int                      lo;
            int                      hi;
            int                      mid;
            bit                      hit;
            r = '0;
            r.status = ST_OK;
            k = c.key;
            case (c.action)
                ACT_CLEAR:
                begin
                    held = 0;
                end
                ACT_INSERT:
                begin
                    if (held >= TABLE_DEPTH)
                    begin
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        j = held;
                        while (j > 0 && k < keys[j-1])
                        begin
                            keys[j] = keys[j-1];
                            j--;
                        end
                        keys[j] = k;
                        held++;
                        r.position = 7'(j);
                    end
                end
                ACT_SEARCH:
                begin
                    lo  = 0;
                    hi  = held - 1;
                    hit = 1'b0;
                    while (!hit && lo <= hi)
                    begin
                        mid = (lo + hi) / 2;
                        if (k == keys[mid])
                            hit = 1'b1;
                        else if (k < keys[mid])
                            hi = mid - 1;
                        else
                            lo = mid + 1;
                    end
                    if (hit)
                        r.position = 7'(mid);
                    else
                        r.status = ST_MISS;
                end
                default:
                begin
                end
            endcase
            r.stored_count = 8'(held);
            expected_q.push_back(r);
        endfunction

        task check_rsp(skts_rsp_t got);
            skts_rsp_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result with nothing expected: status %0d position %0d count %0d",
                                 got.status, got.position, got.stored_count));
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status)
                report($sformatf("status: got %0d, expected %0d", got.status, want.status));
            if (got.position !== want.position)
                report($sformatf("position: got %0d, expected %0d", got.position, want.position));
            if (got.stored_count !== want.stored_count)
                report($sformatf("stored_count: got %0d, expected %0d",
                                 got.stored_count, want.stored_count));
        endtask
    endclass

endpackage

/* dv/testbench.sv */
// Testbench top: drives clear, insert and search transfers into the core and checks every result.
`timescale 1ns / 1ps
module testbench;
    import skts_pkg::*;
    import skts_tb_pkg::*;

    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam int         ITEM_GOAL   = 650;
    localparam int         CYCLE_LIMIT = 1_000_000;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      start;
    logic      busy;
    skts_cmd_t cmd;
    logic      done;
    skts_rsp_t rsp;

    key_table_scoreboard     sb;
    logic signed [KEY_W-1:0] loaded_keys [$];
    int                      sent;
    int                      burst_left;
    int                      cycles;

    sorted_key_table_search_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        #10;
        clk = 1'b1;
        #10;
        clk = 1'b0;
    end

    initial cycles = 0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_rsp(rsp);
    end

    function automatic logic signed [KEY_W-1:0] rand_key();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 16) - 8;
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: return $urandom_range(0, 400) - 200;
        endcase
    endfunction

    // one transfer; start stays high into the next call unless a gap is taken
    task automatic send_cmd(input logic [1:0] act, input logic signed [KEY_W-1:0] k);
        skts_cmd_t c;
        c.action = act;
        c.key    = k;
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        sb.note_cmd(c);
        sent++;
        if (act == ACT_CLEAR)
            loaded_keys.delete();
        else if (act == ACT_INSERT && loaded_keys.size() < TABLE_DEPTH)
            loaded_keys.push_back(k);
        burst_left--;
        if (burst_left <= 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 6);
        end
    endtask

    task automatic drain();
        if (start)
            start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [KEY_W-1:0] probe_key();
        logic signed [KEY_W-1:0] k;
        if (loaded_keys.size() > 0 && $urandom_range(0, 2) != 0)
        begin
            k = loaded_keys[$urandom_range(0, loaded_keys.size() - 1)];
            if ($urandom_range(0, 4) == 0)
                k = k + 1;
            return k;
        end
        return rand_key();
    endfunction

    // clear (always when filling, else at random), a run of inserts mixed with searches, plus a little noise
    task automatic run_phase(input bit fill);
        int                      n_ins;
        int                      n_srch;
        int                      order;
        int                      step_no;
        int                      base;
        logic signed [KEY_W-1:0] k;
        if (fill || $urandom_range(0, 1) == 0)
            send_cmd(ACT_CLEAR, rand_key());
        n_ins   = fill ? TABLE_DEPTH + $urandom_range(1, 3) : $urandom_range(0, 12);
        n_srch  = $urandom_range(2, 14);
        order   = $urandom_range(0, 2);
        base    = $urandom_range(0, 2000) - 1000;
        step_no = 0;
        while (n_ins + n_srch > 0)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                send_cmd(ACT_UNUSED, rand_key());
            end
            else if (!fill && $urandom_range(0, 59) == 0)
            begin
                send_cmd(ACT_CLEAR, rand_key());
            end
            else if (n_ins > 0 && (n_srch == 0 || $urandom_range(0, 2) != 0))
            begin
                case (order)
                    1: k = base - step_no * 3;
                    2: k = base + step_no * 3;
                    default: k = rand_key();
                endcase
                send_cmd(ACT_INSERT, k);
                step_no++;
                n_ins--;
            end
            else
            begin
                send_cmd(ACT_SEARCH, probe_key());
                n_srch--;
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        cmd        = '0;
        sent       = 0;
        burst_left = 3;
        sb         = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, duplicates, every action, misses and empty table
        send_cmd(ACT_SEARCH, 32'sh0000_0000);
        send_cmd(ACT_INSERT, 32'sh0000_0000);
        send_cmd(ACT_INSERT, 32'sh7fff_ffff);
        send_cmd(ACT_INSERT, 32'sh8000_0000);
        send_cmd(ACT_INSERT, 32'shffff_ffff);
        send_cmd(ACT_INSERT, 32'shffff_ffff);
        send_cmd(ACT_INSERT, 32'sh0000_0001);
        send_cmd(ACT_SEARCH, 32'sh8000_0000);
        send_cmd(ACT_SEARCH, 32'sh7fff_ffff);
        send_cmd(ACT_SEARCH, 32'shffff_ffff);
        send_cmd(ACT_SEARCH, 32'sh0000_0000);
        send_cmd(ACT_SEARCH, 32'sh0000_0005);
        send_cmd(ACT_SEARCH, 32'sh7fff_fffe);
        send_cmd(ACT_UNUSED, 32'sh5a5a_5a5a);
        send_cmd(ACT_INSERT, 32'sh5555_5555);
        send_cmd(ACT_SEARCH, 32'shaaaa_aaaa);
        send_cmd(ACT_CLEAR,  32'shffff_ffff);
        send_cmd(ACT_SEARCH, 32'shffff_ffff);
        send_cmd(ACT_INSERT, 32'sh0000_0003);
        send_cmd(ACT_UNUSED, 32'sh0000_0000);
        send_cmd(ACT_CLEAR,  32'sh0000_0000);
        drain();

        // fill to the top so inserts get refused
        run_phase(1'b1);
        drain();

        while (sent < ITEM_GOAL)
        begin
            run_phase($urandom_range(0, 11) == 0);
            if ($urandom_range(0, 3) == 0)
                drain();
        end

        drain();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
